@@ hdl/spm_pkg.sv @@
// ----------------------------------------------------------------------------
// spm_pkg
// shared types and constants for the streaming pattern matcher
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int BYTE_W  = 8;
  localparam int POS_W   = 16;
  localparam int COUNT_W = 16;

  // input item kinds
  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_TEXT    = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // per-cycle control broadcast along the cell row
  typedef struct packed {
    logic win_shift;  // shift text window by one byte
    logic win_clear;  // clear text window (after the shift compare)
    logic pat_shift;  // shift pattern row by one byte
    logic ok_load;    // capture compare result of shifted window
  } cell_ctl_t;

  // item token handed to the result stage
  typedef struct packed {
    logic             is_text;
    logic             last;
    logic             cand;       // window full enough and pattern present
    logic [POS_W-1:0] start_pos;  // one-based start if the compare hits
  } tok_t;

endpackage

@@ hdl/spm_cell.sv @@
// ----------------------------------------------------------------------------
// spm_cell
// one window slot: holds a text byte and a pattern byte, compares them
// ----------------------------------------------------------------------------
module spm_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  spm_pkg::cell_ctl_t          ctl,
  input  logic [spm_pkg::BYTE_W-1:0]  win_in,
  input  logic [spm_pkg::BYTE_W-1:0]  pat_in,
  input  logic                        beyond,
  output logic [spm_pkg::BYTE_W-1:0]  win_out,
  output logic [spm_pkg::BYTE_W-1:0]  pat_out,
  output logic                        ok
);
  import spm_pkg::*;

  logic [BYTE_W-1:0] win_r;
  logic [BYTE_W-1:0] win_nxt;
  logic [BYTE_W-1:0] pat_r;
  logic              ok_r;

  always_comb begin
    win_nxt = win_r;
    if (ctl.win_clear) begin
      win_nxt = '0;
    end else if (ctl.win_shift) begin
      win_nxt = win_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

  // pattern byte and compare flag carry no reset
  always_ff @(posedge clk) begin
    if (ctl.pat_shift) begin
      pat_r <= pat_in;
    end
    if (ctl.ok_load) begin
      // slots past the pattern length always agree
      ok_r <= (win_in == pat_r) || beyond;
    end
  end

  assign win_out = win_r;
  assign pat_out = pat_r;
  assign ok      = ok_r;

endmodule

@@ hdl/spm_result.sv @@
// ----------------------------------------------------------------------------
// spm_result
// result stage: match decision, running count, output register
// ----------------------------------------------------------------------------
module spm_result (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tok_load,
  input  spm_pkg::tok_t                tok_in,
  output logic                         tok_ready,
  input  logic                         ok_all,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [spm_pkg::POS_W-1:0]    out_match_position,
  output logic [spm_pkg::COUNT_W-1:0]  out_match_count
);
  import spm_pkg::*;

  logic               tok_valid_r;
  logic               tok_valid_nxt;
  tok_t               tok_r;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic [COUNT_W-1:0] count_inc;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [POS_W-1:0]   out_pos_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               hit;
  logic               adv;

  assign hit       = tok_valid_r && tok_r.is_text && tok_r.cand && ok_all;
  assign adv       = tok_valid_r && (!hit || !out_valid_r || out_ready);
  assign tok_ready = !tok_valid_r || adv;
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;

  always_comb begin
    tok_valid_nxt = tok_valid_r;
    if (tok_load) begin
      tok_valid_nxt = 1'b1;
    end else if (adv) begin
      tok_valid_nxt = 1'b0;
    end

    count_nxt = count_r;
    if (adv) begin
      if (!tok_r.is_text || tok_r.last) begin
        count_nxt = '0;
      end else if (hit) begin
        count_nxt = count_inc;
      end
    end

    out_valid_nxt = out_valid_r;
    if (adv && hit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_load) begin
      tok_r <= tok_in;
    end
    if (adv && hit) begin
      out_pos_r   <= tok_r.start_pos;
      out_count_r <= count_inc;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_match_position = out_pos_r;
  assign out_match_count    = out_count_r;

endmodule

@@ hdl/streaming_pattern_match_top.sv @@
// result path: a text byte that completes a match passes the registered slot
//   compares and token, then the output register; a stalled output can delay it
// throughput: one item per cycle, text or pattern, unless a hit stalls on out_ready
// reset: pattern length, load index, text position, match count and window clear;
//   pattern bytes hold no reset value and are only compared once loaded
// ----------------------------------------------------------------------------
// streaming_pattern_match_top
// naive string matcher built as a row of byte cells
// ----------------------------------------------------------------------------
module streaming_pattern_match_top #(
  parameter int          MAX_PATTERN = 32,
  parameter int unsigned MAX_TEXT    = 65535
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [spm_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [spm_pkg::POS_W-1:0]    out_match_position,
  output logic [spm_pkg::COUNT_W-1:0]  out_match_count
);
  import spm_pkg::*;

  // width of a pattern length or load index (holds MAX_PATTERN itself)
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);
  // positions stop counting at the lesser of MAX_TEXT and the field range
  localparam logic [POS_W-1:0] POS_LIMIT =
    (MAX_TEXT < 65535) ? POS_W'(MAX_TEXT) : {POS_W{1'b1}};

  // stage 0 state: pattern bookkeeping and text position
  logic [LEN_W-1:0] plen_r;
  logic [LEN_W-1:0] plen_nxt;
  logic [LEN_W-1:0] idx_r;
  logic [LEN_W-1:0] idx_nxt;
  logic [LEN_W-1:0] idx_after;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [POS_W-1:0] pos_new;
  logic [POS_W-1:0] plen_ext;

  logic       accept;
  logic       text_acc;
  logic       pat_acc;
  logic       text_active;
  logic       tok_ready;
  cell_ctl_t  ctl;
  tok_t       tok;

  // cell row wiring: slot 0 holds the newest text byte
  logic [BYTE_W-1:0]      win_q [MAX_PATTERN];
  logic [BYTE_W-1:0]      pat_q [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] ok_vec;
  logic [MAX_PATTERN-1:0] beyond;
  logic                   ok_all;

  assign in_ready = tok_ready;
  assign accept   = in_valid && in_ready;
  assign text_acc = accept && (in_kind == KIND_TEXT);
  assign pat_acc  = accept && (in_kind == KIND_PATTERN);

  // text past the position limit is dropped until its last byte
  assign text_active = (pos_r < POS_LIMIT);
  assign pos_new     = pos_r + 1'b1;
  assign plen_ext    = POS_W'(plen_r);
  // pattern bytes beyond the row are ignored, the index saturates
  assign idx_after   = (idx_r < LEN_MAX) ? idx_r + 1'b1 : idx_r;

  // control for the cell row: the compare uses the shifted window before
  // any end-of-text clear takes effect
  always_comb begin
    ctl.win_shift = text_acc && text_active;
    ctl.ok_load   = text_acc && text_active;
    ctl.win_clear = pat_acc || (text_acc && in_last);
    ctl.pat_shift = pat_acc && (idx_r < LEN_MAX);
  end

  // pattern bytes shift in at slot 0, so after loading L bytes slot j holds
  // pattern byte L-1-j, which lines up with text byte j of the window
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [BYTE_W-1:0] win_in;
    logic [BYTE_W-1:0] pat_in;

    if (j == 0) begin : g_head
      assign win_in = in_data_byte;
      assign pat_in = in_data_byte;
    end else begin : g_link
      assign win_in = win_q[j-1];
      assign pat_in = pat_q[j-1];
    end

    assign beyond[j] = ((LEN_W+1)'(j) >= {1'b0, plen_r});

    spm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .win_in  (win_in),
      .pat_in  (pat_in),
      .beyond  (beyond[j]),
      .win_out (win_q[j]),
      .pat_out (pat_q[j]),
      .ok      (ok_vec[j])
    );
  end

  assign ok_all = &ok_vec;

  // token describing this transaction for the result stage
  always_comb begin
    tok.is_text   = (in_kind == KIND_TEXT);
    tok.last      = in_last;
    tok.cand      = text_active && (plen_r != '0) && (pos_new >= plen_ext);
    tok.start_pos = pos_new - plen_ext + 1'b1;
  end

  always_comb begin
    plen_nxt = plen_r;
    idx_nxt  = idx_r;
    pos_nxt  = pos_r;
    if (pat_acc) begin
      pos_nxt = '0;
      // first byte of a new pattern drops the old one
      if (idx_r == '0) begin
        plen_nxt = '0;
      end
      idx_nxt = idx_after;
      if (in_last) begin
        plen_nxt = idx_after;
        idx_nxt  = '0;
      end
    end else if (text_acc) begin
      if (in_last) begin
        pos_nxt = '0;
      end else if (text_active) begin
        pos_nxt = pos_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0;
      idx_r  <= '0;
      pos_r  <= '0;
    end else begin
      plen_r <= plen_nxt;
      idx_r  <= idx_nxt;
      pos_r  <= pos_nxt;
    end
  end

  spm_result u_result (
    .clk                (clk),
    .rst_n              (rst_n),
    .tok_load           (accept),
    .tok_in             (tok),
    .tok_ready          (tok_ready),
    .ok_all             (ok_all),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_match_position (out_match_position),
    .out_match_count    (out_match_count)
  );

`ifndef SYNTHESIS
  // loaded length never exceeds the cell row
  a_plen_range: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r <= LEN_MAX)
    else $error("pattern length beyond cell row");

  // text position never passes its limit
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LIMIT)
    else $error("text position beyond limit");

  // a pattern transaction restarts the text
  a_pat_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == KIND_PATTERN) |=> (pos_r == '0))
    else $error("pattern load did not clear text position");

  // a reported match always has a real start and a nonzero count
  a_out_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_match_position != '0 && out_match_count != '0))
    else $error("result with zero position or count");
`endif

endmodule
